// ----- rtl/fa_alu_pkg.sv -----
// Shared types, codes and constants for the fraction accumulator ALU.
package fa_alu_pkg;

   localparam int DATA_W = 32;

   typedef logic [DATA_W-1:0] word_type;

   typedef enum logic [2:0] {
      ACT_LOAD = 3'd0,
      ACT_ADD  = 3'd1,
      ACT_SUB  = 3'd2,
      ACT_MUL  = 3'd3,
      ACT_DIV  = 3'd4
   } action_type;

   // Sequencer states of the top level
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_A,
      ST_MUL_B,
      ST_MUL_C,
      ST_COMBINE,
      ST_GCD_TEST,
      ST_GCD_WAIT,
      ST_RED_N,
      ST_RED_N_WAIT,
      ST_RED_D,
      ST_RED_D_WAIT,
      ST_MIX,
      ST_MIX_WAIT,
      ST_MIX_REST,
      ST_OUT
   } state_type;

   // Divider states
   typedef enum logic [1:0] {
      DV_IDLE,
      DV_RUN,
      DV_FIX
   } div_state_type;

   // Wrap-around 32-bit product
   function automatic word_type mul32(input word_type a, input word_type b);
      logic [2*DATA_W-1:0] p;
      p = a * b;
      return p[DATA_W-1:0];
   endfunction

endpackage

// ----- rtl/fa_alu_if.sv -----
// Valid/ready channel carrying one item of payload type T.
interface fa_alu_if #(parameter type T = logic) (input logic clock);
   logic valid;
   logic ready;
   T     payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/fa_alu_div.sv -----
// Iterative truncating signed divider, one quotient bit per cycle.
module fa_alu_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  fa_alu_pkg::word_type dividend,
   input  fa_alu_pkg::word_type divisor,
   output logic                 done,
   output fa_alu_pkg::word_type quotient,
   output fa_alu_pkg::word_type remainder
);
   import fa_alu_pkg::*;

   localparam int CNT_W = $clog2(DATA_W);

   div_state_type       state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   word_type            quo_ff, quo_in;
   word_type            rem_ff, rem_in;
   word_type            dsr_ff, dsr_in;
   logic                qneg_ff, qneg_in;
   logic                rneg_ff, rneg_in;
   logic [DATA_W:0]     trial;
   word_type            shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
      qneg_ff  <= qneg_in;
      rneg_ff  <= rneg_in;
   end

   // Restoring step on magnitudes
   always_comb begin
      shifted = {rem_ff[DATA_W-2:0], quo_ff[DATA_W-1]};
      trial   = {rem_ff, quo_ff[DATA_W-1]} - {1'b0, dsr_ff};
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      qneg_in  = qneg_ff;
      rneg_in  = rneg_ff;
      done     = 1'b0;
      unique case (state_ff)
         DV_IDLE: begin
            if (start) begin
               quo_in   = dividend[DATA_W-1] ? word_type'(-dividend) : dividend;
               dsr_in   = divisor[DATA_W-1] ? word_type'(-divisor) : divisor;
               rem_in   = '0;
               count_in = '0;
               qneg_in  = dividend[DATA_W-1] ^ divisor[DATA_W-1];
               rneg_in  = dividend[DATA_W-1];
               state_in = DV_RUN;
            end
         end
         DV_RUN: begin
            // Shift in the next dividend bit and subtract when it fits
            if (!trial[DATA_W]) begin
               rem_in = trial[DATA_W-1:0];
               quo_in = {quo_ff[DATA_W-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[DATA_W-2:0], 1'b0};
            end
            count_in = count_ff + 1'b1;
            if (count_ff == CNT_W'(DATA_W-1)) begin
               state_in = DV_FIX;
            end
         end
         DV_FIX: begin
            // Apply signs and report
            quo_in   = qneg_ff ? word_type'(-quo_ff) : quo_ff;
            rem_in   = rneg_ff ? word_type'(-rem_ff) : rem_ff;
            state_in = DV_IDLE;
            done     = 1'b1;
         end
         default: state_in = DV_IDLE;
      endcase
   end

   assign quotient  = qneg_ff ? word_type'(-quo_ff) : quo_ff;
   assign remainder = rneg_ff ? word_type'(-rem_ff) : rem_ff;

endmodule

// ----- rtl/fraction_accumulator_alu_core.sv -----
// Top level: fraction accumulator with GCD reduction on a shared divider.
// Per item the divider runs the Euclid GCD steps, then up to three more divides
// (reduce numerator, reduce denominator, mixed form).
// Throughput: one item at a time; req_ready is high only in the idle state.
// All arithmetic divides run through one 32-step shift-subtract divider.
// Reset (synchronous, active high) loads the held fraction with 0/1.
module fraction_accumulator_alu_core (
   input logic      clock,
   input logic      reset,
   fa_alu_if.sink   req,
   fa_alu_if.source rsp
);
   import fa_alu_pkg::*;

   state_type  state_ff, state_in;
   word_type   held_num_ff, held_num_in;
   word_type   held_den_ff, held_den_in;
   logic [2:0] act_ff, act_in;
   word_type   x_ff, x_in, y_ff, y_in;
   word_type   pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in;
   word_type   n_ff, n_in, d_ff, d_in;
   word_type   ga_ff, ga_in, gb_ff, gb_in;
   word_type   rn_ff, rn_in;
   word_type   whole_ff, whole_in;
   word_type   out_num_ff, out_num_in, out_den_ff, out_den_in;
   word_type   out_rem_ff, out_rem_in;
   logic       out_err_ff, out_err_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       div_start, div_done;
   word_type   div_a, div_b, div_q, div_r;
   word_type   mul_a, mul_b, mul_p;

   fa_alu_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // One shared multiplier
   assign mul_p = mul32(mul_a, mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         held_num_ff  <= '0;
         held_den_ff  <= word_type'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_num_ff  <= held_num_in;
         held_den_ff  <= held_den_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff     <= act_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      pa_ff      <= pa_in;
      pb_ff      <= pb_in;
      pc_ff      <= pc_in;
      n_ff       <= n_in;
      d_ff       <= d_in;
      ga_ff      <= ga_in;
      gb_ff      <= gb_in;
      rn_ff      <= rn_in;
      whole_ff   <= whole_in;
      out_num_ff <= out_num_in;
      out_den_ff <= out_den_in;
      out_rem_ff <= out_rem_in;
      out_err_ff <= out_err_in;
   end

   always_comb begin
      state_in     = state_ff;
      held_num_in  = held_num_ff;
      held_den_in  = held_den_ff;
      act_in       = act_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      pc_in        = pc_ff;
      n_in         = n_ff;
      d_in         = d_ff;
      ga_in        = ga_ff;
      gb_in        = gb_ff;
      rn_in        = rn_ff;
      whole_in     = whole_ff;
      out_num_in   = out_num_ff;
      out_den_in   = out_den_ff;
      out_rem_in   = out_rem_ff;
      out_err_in   = out_err_ff;
      rsp_valid_in = rsp_valid_ff;
      div_start    = 1'b0;
      div_a        = ga_ff;
      div_b        = gb_ff;
      mul_a        = y_ff;
      mul_b        = held_num_ff;
      req.ready    = 1'b0;

      // Drop the result once taken
      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = !rsp_valid_ff;
            if (req.valid && !rsp_valid_ff) begin
               act_in     = req.payload.action;
               x_in       = req.payload.operand_num;
               y_in       = req.payload.operand_den;
               out_err_in = 1'b0;
               state_in   = ST_MUL_A;
            end
         end
         ST_MUL_A: begin
            // y*n (or n*x / n*y for multiply and divide)
            unique case (act_ff)
               ACT_MUL: mul_b = x_ff;
               default: mul_b = y_ff;
            endcase
            mul_a = held_num_ff;
            if (act_ff == ACT_ADD || act_ff == ACT_SUB) begin
               mul_a = y_ff;
               mul_b = held_num_ff;
            end
            pa_in    = mul_p;
            state_in = ST_MUL_B;
         end
         ST_MUL_B: begin
            // x*d
            mul_a    = x_ff;
            mul_b    = held_den_ff;
            pb_in    = mul_p;
            state_in = ST_MUL_C;
         end
         ST_MUL_C: begin
            // d*y
            mul_a    = held_den_ff;
            mul_b    = y_ff;
            pc_in    = mul_p;
            state_in = ST_COMBINE;
         end
         ST_COMBINE: begin
            state_in = ST_GCD_TEST;
            case (act_ff)
               ACT_LOAD: begin
                  n_in = x_ff;
                  d_in = y_ff;
               end
               ACT_ADD, ACT_SUB: begin
                  if (held_den_ff != y_ff) begin
                     n_in = (act_ff == ACT_ADD) ? pa_ff + pb_ff : pa_ff - pb_ff;
                     d_in = pc_ff;
                  end else begin
                     n_in = (act_ff == ACT_ADD) ? held_num_ff + x_ff
                                                : held_num_ff - x_ff;
                     d_in = y_ff;
                  end
               end
               ACT_MUL: begin
                  n_in = pa_ff;
                  d_in = pc_ff;
               end
               ACT_DIV: begin
                  n_in = pa_ff;
                  d_in = pb_ff;
               end
               default: state_in = ST_MIX;
            endcase
            ga_in = n_in;
            gb_in = d_in;
         end
         ST_GCD_TEST: begin
            // Euclid: stop when the divisor reaches zero
            if (gb_ff == '0) begin
               if (ga_ff == '0) begin
                  out_err_in = 1'b1;
                  state_in   = ST_MIX;
               end else begin
                  state_in = ST_RED_N;
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_GCD_WAIT;
            end
         end
         ST_GCD_WAIT: begin
            if (div_done) begin
               ga_in    = gb_ff;
               gb_in    = div_r;
               state_in = ST_GCD_TEST;
            end
         end
         ST_RED_N: begin
            div_a     = n_ff;
            div_b     = ga_ff;
            div_start = 1'b1;
            state_in  = ST_RED_N_WAIT;
         end
         ST_RED_N_WAIT: begin
            if (div_done) begin
               rn_in    = div_q;
               state_in = ST_RED_D;
            end
         end
         ST_RED_D: begin
            div_a     = d_ff;
            div_b     = ga_ff;
            div_start = 1'b1;
            state_in  = ST_RED_D_WAIT;
         end
         ST_RED_D_WAIT: begin
            if (div_done) begin
               if (div_q == '0) begin
                  out_err_in = 1'b1;
               end else begin
                  held_num_in = rn_ff;
                  held_den_in = div_q;
               end
               state_in = ST_MIX;
            end
         end
         ST_MIX: begin
            // Mixed form of the held fraction
            div_a = held_num_ff;
            div_b = held_den_ff;
            if (held_den_ff == '0) begin
               whole_in = '0;
               state_in = ST_MIX_REST;
            end else begin
               div_start = 1'b1;
               state_in  = ST_MIX_WAIT;
            end
         end
         ST_MIX_WAIT: begin
            if (div_done) begin
               whole_in = div_q;
               state_in = ST_MIX_REST;
            end
         end
         ST_MIX_REST: begin
            mul_a      = held_den_ff;
            mul_b      = whole_ff;
            out_rem_in = held_num_ff - mul_p;
            out_num_in = held_num_ff;
            out_den_in = held_den_ff;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.valid                  = rsp_valid_ff;
   assign rsp.payload.result_num     = out_num_ff;
   assign rsp.payload.result_den     = out_den_ff;
   assign rsp.payload.whole_part     = whole_ff;
   assign rsp.payload.remainder_part = out_rem_ff;
   assign rsp.payload.error          = out_err_ff;

endmodule

// ----- rtl/fa_alu_checker.sv -----
// Port-level checker for the fraction accumulator ALU, bound to the top level.
module fa_alu_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [31:0] rsp_den,
   input logic rsp_error
);
   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_den))
      else $error("result changed while stalled");

   // No new item taken while a result waits
   a_no_accept_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("item accepted with result pending");

   // Held denominator is never zero in a result
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_den != 32'd0)
      else $error("zero denominator reported");

   // An accepted item yields no result in the next cycle
   a_multi_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result too early");

   // The error flag is always known on a valid result
   a_error_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown(rsp_error))
      else $error("unknown error flag reported");
endmodule

bind fraction_accumulator_alu_core fa_alu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_den   (rsp.payload.result_den),
   .rsp_error (rsp.payload.error)
);
